[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the touch calibration block.
// Depends on nothing; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define TMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The expression must be false at every rising edge outside reset.
`define TMC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[rtl/tmc_pkg.sv]
// Package of the touch median calibration block: sizes, register map,
// configuration and command structs, controller states. Depends on nothing.
package tmc_pkg;

    localparam int BURST_LEN = 5;
    localparam int SAMPLE_W  = 12;
    localparam int SIZE_W    = 13;
    localparam int CNT_W     = $clog2(BURST_LEN);
    localparam int MID       = BURST_LEN / 2;
    localparam int NUM_W     = SAMPLE_W + SIZE_W;
    localparam int QBITS     = SIZE_W;
    localparam int STEP_W    = $clog2(QBITS);
    localparam int SIZE_MAX  = 4096;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef logic [CNT_W-1:0]                    cnt_t;
    typedef logic [STEP_W-1:0]                   step_t;
    typedef logic [SAMPLE_W-1:0]                 sample_t;
    typedef logic [SIZE_W-1:0]                   size_t;
    typedef logic [NUM_W-1:0]                    num_t;
    typedef logic [BURST_LEN-1:0][SAMPLE_W-1:0]  burst_t;

    typedef enum logic [2:0] {
        REG_X_RAW_MIN     = 3'd0,
        REG_X_RAW_MAX     = 3'd1,
        REG_Y_RAW_MIN     = 3'd2,
        REG_Y_RAW_MAX     = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_VALID_LOW     = 3'd6,
        REG_VALID_HIGH    = 3'd7
    } reg_idx_t;

    localparam sample_t RST_X_RAW_MIN     = 12'd0;
    localparam sample_t RST_X_RAW_MAX     = 12'd4095;
    localparam sample_t RST_Y_RAW_MIN     = 12'd0;
    localparam sample_t RST_Y_RAW_MAX     = 12'd4095;
    localparam size_t   RST_SCREEN_WIDTH  = 13'd240;
    localparam size_t   RST_SCREEN_HEIGHT = 13'd320;
    localparam sample_t RST_VALID_LOW     = 12'd150;
    localparam sample_t RST_VALID_HIGH    = 12'd3950;

    typedef struct packed {
        sample_t x_raw_min;
        sample_t x_raw_max;
        sample_t y_raw_min;
        sample_t y_raw_max;
        size_t   screen_width;
        size_t   screen_height;
        sample_t valid_low;
        sample_t valid_high;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic wr_en;
        cnt_t wr_idx;
        logic med_en;
        logic mul_en;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

endpackage

[rtl/touch_median_calibrate.sv]
// Top level of the touch median filter with linear screen calibration.
// Depends on tmc_pkg, tmc_regs, tmc_ctrl and tmc_datapath.
//
//   port group   direction  handshake            payload
//   samples      in         in_valid / in_stall  x_sample, y_sample
//   result       out        out_valid/out_stall  pressed, x_pos, y_pos, x_median, y_median
//   config       in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A request that does not close a burst of five is taken without a stall.
// The fifth request stalls the input through the median, the multiply, 13 steps
// of the restoring divider and the result load.
// The load waits, and the stall grows, while an earlier result is still stalled.
// The result register lets the next burst be collected while a result waits.
// rst_n resets control and configuration to their reset values and clears the held coordinates.
module touch_median_calibrate (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  tmc_pkg::sample_t            x_sample,
    input  tmc_pkg::sample_t            y_sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pressed,
    output tmc_pkg::sample_t            x_pos,
    output tmc_pkg::sample_t            y_pos,
    output tmc_pkg::sample_t            x_median,
    output tmc_pkg::sample_t            y_median,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tmc_pkg::DATA_W-1:0]  pwdata,
    output logic [tmc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    tmc_pkg::cfg_t    cfg;
    tmc_pkg::dp_cmd_t cmd;

    assign pready = 1'b1;

    tmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tmc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .x_sample (x_sample),
        .y_sample (y_sample),
        .pressed  (pressed),
        .x_pos    (x_pos),
        .y_pos    (y_pos),
        .x_median (x_median),
        .y_median (y_median)
    );

endmodule

[rtl/tmc_regs.sv]
// Configuration register file with an APB-style write and read port.
// Depends on tmc_pkg for the register map and the cfg_t struct.
module tmc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tmc_pkg::ADDR_W-1:0]    paddr,
    input  logic [tmc_pkg::DATA_W-1:0]    pwdata,
    output logic [tmc_pkg::DATA_W-1:0]    prdata,
    output tmc_pkg::cfg_t                 cfg
);

    tmc_pkg::cfg_t     cfg_reg;
    tmc_pkg::cfg_t     cfg_next;
    tmc_pkg::reg_idx_t idx;
    logic              wr;

    assign idx = tmc_pkg::reg_idx_t'(paddr[tmc_pkg::ADDR_W-1:2]);
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                tmc_pkg::REG_X_RAW_MIN:     cfg_next.x_raw_min     = pwdata[11:0];
                tmc_pkg::REG_X_RAW_MAX:     cfg_next.x_raw_max     = pwdata[11:0];
                tmc_pkg::REG_Y_RAW_MIN:     cfg_next.y_raw_min     = pwdata[11:0];
                tmc_pkg::REG_Y_RAW_MAX:     cfg_next.y_raw_max     = pwdata[11:0];
                tmc_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[12:0];
                tmc_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[12:0];
                tmc_pkg::REG_VALID_LOW:     cfg_next.valid_low     = pwdata[11:0];
                tmc_pkg::REG_VALID_HIGH:    cfg_next.valid_high    = pwdata[11:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tmc_pkg::REG_X_RAW_MIN:     prdata = tmc_pkg::DATA_W'(cfg_reg.x_raw_min);
            tmc_pkg::REG_X_RAW_MAX:     prdata = tmc_pkg::DATA_W'(cfg_reg.x_raw_max);
            tmc_pkg::REG_Y_RAW_MIN:     prdata = tmc_pkg::DATA_W'(cfg_reg.y_raw_min);
            tmc_pkg::REG_Y_RAW_MAX:     prdata = tmc_pkg::DATA_W'(cfg_reg.y_raw_max);
            tmc_pkg::REG_SCREEN_WIDTH:  prdata = tmc_pkg::DATA_W'(cfg_reg.screen_width);
            tmc_pkg::REG_SCREEN_HEIGHT: prdata = tmc_pkg::DATA_W'(cfg_reg.screen_height);
            tmc_pkg::REG_VALID_LOW:     prdata = tmc_pkg::DATA_W'(cfg_reg.valid_low);
            tmc_pkg::REG_VALID_HIGH:    prdata = tmc_pkg::DATA_W'(cfg_reg.valid_high);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_raw_min     <= tmc_pkg::RST_X_RAW_MIN;
            cfg_reg.x_raw_max     <= tmc_pkg::RST_X_RAW_MAX;
            cfg_reg.y_raw_min     <= tmc_pkg::RST_Y_RAW_MIN;
            cfg_reg.y_raw_max     <= tmc_pkg::RST_Y_RAW_MAX;
            cfg_reg.screen_width  <= tmc_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= tmc_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.valid_low     <= tmc_pkg::RST_VALID_LOW;
            cfg_reg.valid_high    <= tmc_pkg::RST_VALID_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/tmc_datapath.sv]
// Datapath: burst store, rank-based median, calibration multiply, restoring
// divider, clamp and the result registers. Depends on tmc_pkg.
module tmc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tmc_pkg::cfg_t       cfg,
    input  tmc_pkg::dp_cmd_t    cmd,
    input  tmc_pkg::sample_t    x_sample,
    input  tmc_pkg::sample_t    y_sample,
    output logic                pressed,
    output tmc_pkg::sample_t    x_pos,
    output tmc_pkg::sample_t    y_pos,
    output tmc_pkg::sample_t    x_median,
    output tmc_pkg::sample_t    y_median
);

    // The median is the element whose rank is the middle one; equal values
    // are ranked by position so that the ranks form a permutation.
    function automatic tmc_pkg::sample_t median_of(input tmc_pkg::burst_t a);
        tmc_pkg::sample_t m;
        tmc_pkg::cnt_t    rank;
        m = '0;
        for (int i = 0; i < tmc_pkg::BURST_LEN; i++)
        begin
            rank = '0;
            for (int j = 0; j < tmc_pkg::BURST_LEN; j++)
            begin
                if (a[j] < a[i] || (j < i && a[j] == a[i]))
                    rank = rank + tmc_pkg::cnt_t'(1);
            end
            if (rank == tmc_pkg::cnt_t'(tmc_pkg::MID))
                m = a[i];
        end
        return m;
    endfunction

    // Axis 0 is X, axis 1 is Y throughout.
    tmc_pkg::burst_t  xbuf_reg;
    tmc_pkg::burst_t  ybuf_reg;
    tmc_pkg::sample_t med_reg  [2];
    tmc_pkg::num_t    rem_reg  [2];
    tmc_pkg::num_t    dvs_reg  [2];
    tmc_pkg::size_t   quo_reg  [2];
    tmc_pkg::sample_t span_reg [2];
    tmc_pkg::size_t   sz_reg   [2];
    logic             zero_reg [2];
    logic             press_reg;
    logic             pressed_reg;
    tmc_pkg::sample_t held_reg [2];
    tmc_pkg::sample_t omed_reg [2];

    tmc_pkg::sample_t lo      [2];
    tmc_pkg::sample_t hi      [2];
    tmc_pkg::size_t   size_in [2];
    tmc_pkg::size_t   sz_eff  [2];
    tmc_pkg::sample_t diff    [2];
    tmc_pkg::num_t    prod    [2];
    tmc_pkg::sample_t span_n  [2];
    logic             zero_n  [2];
    logic             in_win  [2];
    logic             ge      [2];
    logic             ovf     [2];
    tmc_pkg::sample_t result  [2];

    assign lo[0]      = cfg.x_raw_min;
    assign hi[0]      = cfg.x_raw_max;
    assign size_in[0] = cfg.screen_width;
    assign lo[1]      = cfg.y_raw_min;
    assign hi[1]      = cfg.y_raw_max;
    assign size_in[1] = cfg.screen_height;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            sz_eff[a] = (size_in[a] > tmc_pkg::size_t'(tmc_pkg::SIZE_MAX))
                        ? tmc_pkg::size_t'(tmc_pkg::SIZE_MAX) : size_in[a];
            zero_n[a] = (size_in[a] == '0) || (hi[a] <= lo[a]) || (med_reg[a] < lo[a]);
            diff[a]   = med_reg[a] - lo[a];
            prod[a]   = tmc_pkg::num_t'(diff[a]) * tmc_pkg::num_t'(sz_eff[a]);
            span_n[a] = hi[a] - lo[a];
            in_win[a] = (med_reg[a] >= cfg.valid_low) && (med_reg[a] <= cfg.valid_high);
            ge[a]     = rem_reg[a] >= dvs_reg[a];
            // A remainder left at or above the span means the quotient did not
            // fit in the quotient register, so it is far above the screen size.
            ovf[a]    = rem_reg[a] >= tmc_pkg::num_t'(span_reg[a]);
            if (zero_reg[a])
                result[a] = '0;
            else if (ovf[a] || quo_reg[a] >= sz_reg[a])
                result[a] = tmc_pkg::sample_t'(sz_reg[a] - tmc_pkg::size_t'(1));
            else
                result[a] = quo_reg[a][tmc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            xbuf_reg[cmd.wr_idx] <= x_sample;
            ybuf_reg[cmd.wr_idx] <= y_sample;
        end
        if (cmd.med_en)
        begin
            med_reg[0] <= median_of(xbuf_reg);
            med_reg[1] <= median_of(ybuf_reg);
        end
        if (cmd.mul_en)
            press_reg <= in_win[0] && in_win[1];
        for (int a = 0; a < 2; a++)
        begin
            if (cmd.mul_en)
            begin
                rem_reg[a]  <= prod[a];
                dvs_reg[a]  <= tmc_pkg::num_t'(span_n[a]) << (tmc_pkg::QBITS - 1);
                quo_reg[a]  <= '0;
                span_reg[a] <= span_n[a];
                sz_reg[a]   <= sz_eff[a];
                zero_reg[a] <= zero_n[a];
            end
            else if (cmd.div_step)
            begin
                if (ge[a])
                    rem_reg[a] <= rem_reg[a] - dvs_reg[a];
                quo_reg[a] <= {quo_reg[a][tmc_pkg::QBITS-2:0], ge[a]};
                dvs_reg[a] <= dvs_reg[a] >> 1;
            end
        end
        if (cmd.out_load)
        begin
            pressed_reg <= press_reg;
            omed_reg[0] <= med_reg[0];
            omed_reg[1] <= med_reg[1];
        end
    end

    // Held coordinates change only on a pressed result and double as the
    // position outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg[0] <= '0;
            held_reg[1] <= '0;
        end
        else if (cmd.out_load && press_reg)
        begin
            held_reg[0] <= result[0];
            held_reg[1] <= result[1];
        end
    end

    assign pressed  = pressed_reg;
    assign x_pos    = held_reg[0];
    assign y_pos    = held_reg[1];
    assign x_median = omed_reg[0];
    assign y_median = omed_reg[1];

endmodule

[rtl/tmc_ctrl.sv]
// Controller: burst counter, sequencing of median, multiply and divide steps,
// and the result valid flag. Depends on tmc_pkg.
module tmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output tmc_pkg::dp_cmd_t  cmd
);

    tmc_pkg::state_t state_reg;
    tmc_pkg::state_t state_next;
    tmc_pkg::cnt_t   count_reg;
    tmc_pkg::cnt_t   count_next;
    tmc_pkg::step_t  step_reg;
    tmc_pkg::step_t  step_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;
    logic            last;
    logic            step_done;
    logic            out_free;

    assign accept    = in_valid && (state_reg == tmc_pkg::ST_IDLE);
    assign last      = count_reg == tmc_pkg::cnt_t'(tmc_pkg::BURST_LEN - 1);
    assign step_done = step_reg == tmc_pkg::step_t'(tmc_pkg::QBITS - 1);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmc_pkg::ST_IDLE:
                if (accept && last)
                    state_next = tmc_pkg::ST_MEDIAN;
            tmc_pkg::ST_MEDIAN:
                state_next = tmc_pkg::ST_MULT;
            tmc_pkg::ST_MULT:
                state_next = tmc_pkg::ST_DIVIDE;
            tmc_pkg::ST_DIVIDE:
                if (step_done)
                    state_next = tmc_pkg::ST_FINISH;
            tmc_pkg::ST_FINISH:
                if (out_free)
                    state_next = tmc_pkg::ST_IDLE;
            default:
                state_next = tmc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.wr_idx   = count_reg;
        in_stall     = 1'b1;
        unique case (state_reg)
            tmc_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.wr_en  = accept;
            end
            tmc_pkg::ST_MEDIAN: cmd.med_en   = 1'b1;
            tmc_pkg::ST_MULT:   cmd.mul_en   = 1'b1;
            tmc_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            tmc_pkg::ST_FINISH: cmd.out_load = out_free;
            default:            cmd          = '0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
            count_next = last ? '0 : count_reg + tmc_pkg::cnt_t'(1);

        step_next = '0;
        if (state_reg == tmc_pkg::ST_DIVIDE && !step_done)
            step_next = step_reg + tmc_pkg::step_t'(1);

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmc_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/tmc_checker.sv]
// Port-level checker of the touch calibration block, bound to the top level.
// Depends on assert_macros.svh and tmc_pkg.
`include "assert_macros.svh"

module tmc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        pressed,
    input tmc_pkg::sample_t            x_pos,
    input tmc_pkg::sample_t            y_pos,
    input tmc_pkg::sample_t            x_median,
    input tmc_pkg::sample_t            y_median
);

    // A stalled result request keeps its medians and its pressed flag.
    `TMC_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(x_median) &&
        $stable(y_median) && $stable(pressed),
        "stalled result changed")

    // A new result is only produced while the sample input is stalled.
    `TMC_ASSERT(a_new_result, clk, rst_n, $rose(out_valid) |-> $past(in_stall),
        "result appeared outside a burst")

    // The reported position moves only together with a pressed result.
    `TMC_ASSERT_NEVER(a_pos_move, clk, rst_n,
        !($stable(x_pos) && $stable(y_pos)) && !(out_valid && pressed),
        "position moved without press")

    // After a result is taken, a result in the next cycle must be a fresh load.
    `TMC_ASSERT(a_taken_fresh, clk, rst_n,
        out_valid && !out_stall |=> !out_valid || $past(in_stall),
        "result repeated after acceptance")

endmodule

bind touch_median_calibrate tmc_checker u_tmc_checker (.*);
